// ----- rtl/srfe_pkg.sv -----
`timescale 1ns / 1ps

package srfe_pkg;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_RXB   = 2'd2;
    localparam logic [1:0] MODE_LINE  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSERVO = 2'd1;
    localparam logic [1:0] ST_BOOTING = 2'd2;
    localparam logic [1:0] ST_CORRUPT = 2'd3;

    localparam logic [7:0] SYNC_OUT  = 8'h96;
    localparam logic [7:0] SYNC_IN   = 8'h69;
    localparam logic [7:0] LEN_WRITE = 8'h02;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    localparam logic [1:0] JOB_READ  = 2'd0;
    localparam logic [1:0] JOB_WRITE = 2'd1;
    localparam logic [1:0] JOB_DONE  = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  addr;
        logic [15:0] value;
        logic [1:0]  status;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

endpackage

// ----- rtl/srfe_if.sv -----
`timescale 1ns / 1ps

interface srfe_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  reg_addr;
    logic [15:0] write_value;
    logic [7:0]  rx_byte;
    logic        rx_error;
    logic        line_high;

    modport source (
        output valid, mode, reg_addr, write_value, rx_byte, rx_error, line_high,
        input  ready
    );
    modport sink (
        input  valid, mode, reg_addr, write_value, rx_byte, rx_error, line_high,
        output ready
    );
endinterface

interface srfe_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [1:0]  status;
    logic [15:0] read_value;

    modport source (
        output valid, kind, tx_byte, last, status, read_value,
        input  ready
    );
    modport sink (
        input  valid, kind, tx_byte, last, status, read_value,
        output ready
    );
endinterface

// ----- rtl/srfe_front.sv -----
`timescale 1ns / 1ps

module srfe_front (
    input  logic                clk,
    input  logic                rst_n,
    srfe_cmd_if.sink            cmd,
    input  srfe_pkg::q_flags_t  q_flags,
    output logic                push,
    output srfe_pkg::job_t      job
);
    import srfe_pkg::*;

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_WAIT_LOW  = 2'd1;
    localparam logic [1:0] PH_RECV      = 2'd2;
    localparam logic [1:0] PH_WAIT_HIGH = 2'd3;

    logic [1:0] phase_reg, phase_next;
    logic [2:0] byte_index_reg, byte_index_next;
    logic [7:0] pending_addr_reg, pending_addr_next;
    logic       reply_bad_reg, reply_bad_next;
    logic [7:0] reply_sum_reg, reply_sum_next;
    logic [7:0] reply_low_reg, reply_low_next;
    logic [7:0] reply_high_reg, reply_high_next;
    logic       accept;

    assign cmd.ready = !q_flags.full;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        phase_next        = phase_reg;
        byte_index_next   = byte_index_reg;
        pending_addr_next = pending_addr_reg;
        reply_bad_next    = reply_bad_reg;
        reply_sum_next    = reply_sum_reg;
        reply_low_next    = reply_low_reg;
        reply_high_next   = reply_high_reg;
        push              = 1'b0;
        job.kind          = JOB_DONE;
        job.addr          = cmd.reg_addr;
        job.value         = cmd.write_value;
        job.status        = ST_OK;
        if (accept)
        begin
            case (cmd.mode)
                MODE_READ:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        push              = 1'b1;
                        job.kind          = JOB_READ;
                        pending_addr_next = cmd.reg_addr;
                        phase_next        = PH_WAIT_LOW;
                    end
                end
                MODE_WRITE:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        push     = 1'b1;
                        job.kind = JOB_WRITE;
                    end
                end
                MODE_RXB:
                begin
                    if (phase_reg == PH_RECV)
                    begin
                        if (cmd.rx_error)
                            reply_bad_next = 1'b1;
                        case (byte_index_reg)
                            3'd0: if (cmd.rx_byte != SYNC_IN) reply_bad_next = 1'b1;
                            3'd2: if (cmd.rx_byte != pending_addr_reg) reply_bad_next = 1'b1;
                            3'd3: if (cmd.rx_byte != LEN_WRITE) reply_bad_next = 1'b1;
                            3'd4: reply_low_next = cmd.rx_byte;
                            3'd5: reply_high_next = cmd.rx_byte;
                            3'd6: if (cmd.rx_byte != reply_sum_reg) reply_bad_next = 1'b1;
                            default: ;
                        endcase
                        if (byte_index_reg inside {[3'd1:3'd5]})
                            reply_sum_next = reply_sum_reg + cmd.rx_byte;
                        if (byte_index_reg >= 3'd6)
                        begin
                            byte_index_next = 3'd0;
                            phase_next      = PH_WAIT_HIGH;
                        end
                        else
                            byte_index_next = byte_index_reg + 3'd1;
                    end
                end
                default:
                begin
                    if (phase_reg == PH_WAIT_LOW)
                    begin
                        if (cmd.line_high)
                        begin
                            push       = 1'b1;
                            job.status = ST_NOSERVO;
                            job.value  = 16'd0;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            byte_index_next = 3'd0;
                            reply_bad_next  = 1'b0;
                            reply_sum_next  = 8'd0;
                            reply_low_next  = 8'd0;
                            reply_high_next = 8'd0;
                            phase_next      = PH_RECV;
                        end
                    end
                    else if (phase_reg == PH_WAIT_HIGH)
                    begin
                        push       = 1'b1;
                        phase_next = PH_IDLE;
                        job.value  = 16'd0;
                        if (!cmd.line_high)
                            job.status = ST_BOOTING;
                        else if (reply_bad_reg)
                            job.status = ST_CORRUPT;
                        else
                            job.value = {reply_high_reg, reply_low_reg};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            byte_index_reg   <= 3'd0;
            pending_addr_reg <= 8'd0;
            reply_bad_reg    <= 1'b0;
            reply_sum_reg    <= 8'd0;
            reply_low_reg    <= 8'd0;
            reply_high_reg   <= 8'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            pending_addr_reg <= pending_addr_next;
            reply_bad_reg    <= reply_bad_next;
            reply_sum_reg    <= reply_sum_next;
            reply_low_reg    <= reply_low_next;
            reply_high_reg   <= reply_high_next;
        end
    end

    a_index_in_recv: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg != 3'd0 |-> phase_reg == PH_RECV)
        else $error("reply byte count outside receive phase");

    a_read_starts_wait: assert property (@(posedge clk) disable iff (!rst_n)
        push && job.kind == JOB_READ |=> phase_reg == PH_WAIT_LOW)
        else $error("read frame queued without waiting for line sample");

    a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        push && job.kind == JOB_WRITE |-> phase_reg == PH_IDLE)
        else $error("write frame queued while read in flight");

endmodule

// ----- rtl/srfe_queue.sv -----
`timescale 1ns / 1ps

module srfe_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  srfe_pkg::job_t      push_job,
    input  logic                pop,
    output srfe_pkg::job_t      head_job,
    output srfe_pkg::q_flags_t  flags
);
    import srfe_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign flags.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign flags.empty = count_reg == '0;
    assign head_job    = entry_reg[rd_ptr_reg];
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !flags.full)
        else $error("job pushed into full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- rtl/srfe_back.sv -----
`timescale 1ns / 1ps

module srfe_back (
    input  logic                clk,
    input  logic                rst_n,
    input  srfe_pkg::job_t      head_job,
    input  srfe_pkg::q_flags_t  q_flags,
    output logic                pop,
    srfe_res_if.source          res
);
    import srfe_pkg::*;

    logic [2:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic        kind_reg;
    logic [7:0]  tx_byte_reg;
    logic        last_reg;
    logic [1:0]  status_reg;
    logic [15:0] read_value_reg;
    logic        load;
    logic        final_step;
    logic        gen_kind;
    logic [7:0]  gen_byte;
    logic        gen_last;
    logic [7:0]  wr_sum;

    assign load   = !q_flags.empty && (!valid_reg || res.ready);
    assign wr_sum = head_job.addr + LEN_WRITE + head_job.value[7:0] + head_job.value[15:8];

    always_comb
    begin
        gen_kind   = 1'b0;
        gen_byte   = ZERO_BYTE;
        gen_last   = 1'b0;
        final_step = 1'b0;
        case (head_job.kind)
            JOB_READ:
            begin
                case (idx_reg)
                    3'd0:    gen_byte = SYNC_OUT;
                    3'd2:    gen_byte = head_job.addr;
                    3'd4:
                    begin
                        gen_byte   = head_job.addr;
                        gen_last   = 1'b1;
                        final_step = 1'b1;
                    end
                    default: gen_byte = ZERO_BYTE;
                endcase
            end
            JOB_WRITE:
            begin
                case (idx_reg)
                    3'd0:    gen_byte = SYNC_OUT;
                    3'd2:    gen_byte = head_job.addr;
                    3'd3:    gen_byte = LEN_WRITE;
                    3'd4:    gen_byte = head_job.value[7:0];
                    3'd5:    gen_byte = head_job.value[15:8];
                    3'd6:
                    begin
                        gen_byte   = wr_sum;
                        gen_last   = 1'b1;
                        final_step = 1'b1;
                    end
                    default: gen_byte = ZERO_BYTE;
                endcase
            end
            default:
            begin
                gen_kind   = 1'b1;
                final_step = 1'b1;
            end
        endcase
    end

    assign pop = load && final_step;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = final_step ? 3'd0 : idx_reg + 3'd1;
            valid_next = 1'b1;
        end
        else if (res.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg       <= gen_kind;
            tx_byte_reg    <= gen_byte;
            last_reg       <= gen_last;
            status_reg     <= gen_kind ? head_job.status : ST_OK;
            read_value_reg <= gen_kind ? head_job.value : 16'd0;
        end
    end

    assign res.valid      = valid_reg;
    assign res.kind       = kind_reg;
    assign res.tx_byte    = tx_byte_reg;
    assign res.last       = last_reg;
    assign res.status     = status_reg;
    assign res.read_value = read_value_reg;

    a_frame_held: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 3'd0 |-> !q_flags.empty && head_job.kind != JOB_DONE)
        else $error("frame in progress without its job at queue head");

endmodule

// ----- rtl/servo_register_frame_engine.sv -----
`timescale 1ns / 1ps
// Channel | Dir | Payload
// cmd     | in  | mode, reg_addr, write_value, rx_byte, rx_error, line_high
// res     | out | kind, tx_byte, last, status, read_value
//
// cmd takes one transfer per cycle while the four-entry job queue has room.
// res gives one transfer per cycle from its output register while res.ready is high:
// 5 for a read frame, 7 for a write frame, 1 for a completion.
// Reset (rst_n low) returns the protocol to idle, empties the queue, drops res.valid.
// res.ready low holds the output; once the queue fills, cmd.ready drops.

module servo_register_frame_engine (
    input  logic       clk,
    input  logic       rst_n,
    srfe_cmd_if.sink   cmd,
    srfe_res_if.source res
);
    import srfe_pkg::*;

    logic     push;
    logic     pop;
    job_t     push_job;
    job_t     head_job;
    q_flags_t q_flags;

    srfe_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_flags (q_flags),
        .push    (push),
        .job     (push_job)
    );

    srfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .flags    (q_flags)
    );

    srfe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_flags  (q_flags),
        .pop      (pop),
        .res      (res)
    );

endmodule
